FILE: design/grouped_tile_schedule_generator_top_assert.svh
// Assertion macros shared by the checker of the grouped tile schedule generator.
// Include this file by its bare name; it depends on nothing else.
`ifndef GROUPED_TILE_SCHEDULE_GENERATOR_TOP_ASSERT_SVH
`define GROUPED_TILE_SCHEDULE_GENERATOR_TOP_ASSERT_SVH

// Same-cycle implication, disabled while reset is high.
`define GTSG_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define GTSG_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

// Next-cycle implication that also holds across reset.
`define GTSG_ASSERT_NXT_ALWAYS(label, clk, ante, cons, msg) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: design/gtsg_pkg.sv
// Types and constants of the grouped tile schedule generator.
// Used by every module of the block; depends on nothing.
package gtsg_pkg;

  localparam int TDATA_W = 168;
  localparam int QUEUE_DEPTH = 2;

  localparam logic [1:0] KIND_START = 2'd0;
  localparam logic [1:0] KIND_TILE  = 2'd1;
  localparam logic [1:0] KIND_TOTAL = 2'd2;

  localparam logic [1:0] REG_BASE_ROWS  = 2'd0;
  localparam logic [1:0] REG_BASE_COLS  = 2'd1;
  localparam logic [1:0] REG_TOTAL_COLS = 2'd2;
  localparam logic [1:0] REG_MAX_BLOCKS = 2'd3;

  localparam logic [15:0] RST_BASE_ROWS  = 16'd128;
  localparam logic [15:0] RST_BASE_COLS  = 16'd256;
  localparam logic [15:0] RST_TOTAL_COLS = 16'd4096;
  localparam logic [20:0] RST_MAX_BLOCKS = 21'd4096;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_START,
    ST_TILE,
    ST_TOTAL
  } gtsg_state_t;

  typedef struct packed {
    logic [15:0] base_rows;
    logic [15:0] base_cols;
    logic [15:0] total_cols;
    logic [20:0] max_blocks;
  } gtsg_cfg_t;

  typedef struct packed {
    logic signed [31:0] row_count;
    logic               positive;
    logic               last;
  } gtsg_item_t;

  typedef struct packed {
    logic [1:0]         record_kind;
    logic [15:0]        group_index;
    logic signed [31:0] start_row;
    logic [15:0]        tile_row_index;
    logic [15:0]        tile_col_index;
    logic [15:0]        tile_rows;
    logic [15:0]        tile_cols;
    logic signed [31:0] group_rows;
    logic [20:0]        block_total;
    logic               last_result;
  } gtsg_result_t;

endpackage

FILE: design/grouped_tile_schedule_generator_top.sv
// Channel   Signals                          Direction  Content
// s_axis    tvalid tready tdata tlast        in         one group's row count
// m_axis    tvalid tready tdata tuser tlast  out        start, tile and total records
// apb       psel penable pwrite paddr ...    in/out     four tiling registers
// A result is held in the output register until m_axis takes it. A group leaves the
// input queue, then the sequencer in gtsg_back emits its start record, its tile
// entries (at most MAX_TILES_PER_GROUP) and, after the last group of a batch, the
// total record; it takes one group at a time. A two-entry queue lets s_axis keep
// accepting while m_axis stalls. Synchronous reset restores the register defaults
// and clears the batch state, the queue and the valid flag of the result register.
module grouped_tile_schedule_generator_top import gtsg_pkg::*; #(
  parameter int MAX_TILES_PER_GROUP = 62
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               s_axis_tvalid,
  output logic               s_axis_tready,
  input  logic [31:0]        s_axis_tdata,  // row_count [31:0]
  input  logic               s_axis_tlast,  // last_group
  output logic               m_axis_tvalid,
  input  logic               m_axis_tready,
  // group_index, start_row, tile_row_index, tile_col_index, tile_rows, tile_cols,
  // group_rows, block_total, then zero fill
  output logic [TDATA_W-1:0] m_axis_tdata,
  output logic [1:0]         m_axis_tuser,  // record_kind
  output logic               m_axis_tlast,  // last_result
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [3:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  gtsg_cfg_t    cfg;
  logic         item_valid;
  gtsg_item_t   item;
  logic         item_pop;
  gtsg_result_t rec;
  logic         cfg_write;

  assign pready = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.base_rows <= RST_BASE_ROWS;
      cfg.base_cols <= RST_BASE_COLS;
      cfg.total_cols <= RST_TOTAL_COLS;
      cfg.max_blocks <= RST_MAX_BLOCKS;
    end else if (cfg_write) begin
      unique case (paddr[3:2])
        REG_BASE_ROWS:  cfg.base_rows <= pwdata[15:0];
        REG_BASE_COLS:  cfg.base_cols <= pwdata[15:0];
        REG_TOTAL_COLS: cfg.total_cols <= pwdata[15:0];
        REG_MAX_BLOCKS: cfg.max_blocks <= pwdata[20:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_BASE_ROWS:  prdata = {16'd0, cfg.base_rows};
      REG_BASE_COLS:  prdata = {16'd0, cfg.base_cols};
      REG_TOTAL_COLS: prdata = {16'd0, cfg.total_cols};
      REG_MAX_BLOCKS: prdata = {11'd0, cfg.max_blocks};
      default:        prdata = '0;
    endcase
  end

  gtsg_front u_front (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .item_valid    (item_valid),
    .item          (item),
    .item_pop      (item_pop)
  );

  gtsg_back #(
    .MAX_TILES_PER_GROUP (MAX_TILES_PER_GROUP)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .item_valid (item_valid),
    .item_in    (item),
    .item_pop   (item_pop),
    .out_valid  (m_axis_tvalid),
    .out_ready  (m_axis_tready),
    .out_rec    (rec)
  );

  assign m_axis_tdata = {3'd0, rec.block_total, rec.group_rows, rec.tile_cols,
                         rec.tile_rows, rec.tile_col_index, rec.tile_row_index,
                         rec.start_row, rec.group_index};
  assign m_axis_tuser = rec.record_kind;
  assign m_axis_tlast = rec.last_result;

endmodule

FILE: design/gtsg_front.sv
// Input side: accepts group transfers, classifies them and queues them.
// Depends on gtsg_pkg.
module gtsg_front import gtsg_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,  // row_count [31:0]
  input  logic        s_axis_tlast,
  output logic        item_valid,
  output gtsg_item_t  item,
  input  logic        item_pop
);

  localparam int PW = $clog2(QUEUE_DEPTH);

  gtsg_item_t      entries [QUEUE_DEPTH];
  logic [PW-1:0]   wr_ptr;
  logic [PW-1:0]   rd_ptr;
  logic [PW:0]     fill;
  logic            push;
  logic            pop;
  gtsg_item_t      incoming;

  assign s_axis_tready = (fill != (PW+1)'(QUEUE_DEPTH));
  assign push = s_axis_tvalid && s_axis_tready;
  assign item_valid = (fill != '0);
  assign pop = item_pop && item_valid;
  assign item = entries[rd_ptr];

  always_comb begin
    incoming.row_count = s_axis_tdata;
    incoming.positive = (s_axis_tdata != 32'd0) && !s_axis_tdata[31];
    incoming.last = s_axis_tlast;
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= incoming;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        fill <= fill + 1'b1;
      end else if (pop && !push) begin
        fill <= fill - 1'b1;
      end
    end
  end

endmodule

FILE: design/gtsg_back.sv
// Output side: walks the tiles of one queued group and drives the result register.
// Holds the batch state; depends on gtsg_pkg.
module gtsg_back import gtsg_pkg::*; #(
  parameter int MAX_TILES_PER_GROUP = 62
) (
  input  logic         clk,
  input  logic         rst,
  input  gtsg_cfg_t    cfg,
  input  logic         item_valid,
  input  gtsg_item_t   item_in,
  output logic         item_pop,
  output logic         out_valid,
  input  logic         out_ready,
  output gtsg_result_t out_rec
);

  localparam int CW = $clog2(MAX_TILES_PER_GROUP + 1);

  gtsg_state_t  state, state_next;
  gtsg_item_t   item, item_next;
  logic [31:0]  rem_rows, rem_rows_next;
  logic [15:0]  rem_cols, rem_cols_next;
  logic [15:0]  row_idx, row_idx_next;
  logic [15:0]  col_idx, col_idx_next;
  logic [CW-1:0] tile_cnt, tile_cnt_next;
  logic [31:0]  running_start_row, running_start_row_next;
  logic [15:0]  group_counter, group_counter_next;
  logic [20:0]  tiles_issued, tiles_issued_next;
  logic         out_valid_next;
  gtsg_result_t out_rec_next;

  logic         can_load;
  logic         load;
  gtsg_result_t rec;
  logic [15:0]  br;
  logic [15:0]  bc;
  logic [15:0]  tile_rows_c;
  logic [15:0]  tile_cols_c;
  logic [20:0]  issued_inc;
  logic [CW-1:0] cnt_inc;
  logic         tiles_go;
  logic         rows_done;
  logic         more;
  logic         finish_group;

  assign can_load = !out_valid || out_ready;
  assign br = (cfg.base_rows == 16'd0) ? 16'd1 : cfg.base_rows;
  assign bc = (cfg.base_cols == 16'd0) ? 16'd1 : cfg.base_cols;
  assign tile_rows_c = (rem_rows > {16'd0, br}) ? br : rem_rows[15:0];
  assign tile_cols_c = (rem_cols > bc) ? bc : rem_cols;
  assign issued_inc = tiles_issued + 21'd1;
  assign cnt_inc = tile_cnt + 1'b1;
  assign tiles_go = item.positive && (cfg.total_cols != 16'd0) &&
                    (tiles_issued < cfg.max_blocks);

  always_comb begin
    state_next = state;
    item_next = item;
    rem_rows_next = rem_rows;
    rem_cols_next = rem_cols;
    row_idx_next = row_idx;
    col_idx_next = col_idx;
    tile_cnt_next = tile_cnt;
    running_start_row_next = running_start_row;
    group_counter_next = group_counter;
    tiles_issued_next = tiles_issued;
    item_pop = 1'b0;
    load = 1'b0;
    rec = '0;
    rows_done = 1'b0;
    more = 1'b0;
    finish_group = 1'b0;

    unique case (state)
      ST_IDLE: begin
        if (item_valid) begin
          item_pop = 1'b1;
          item_next = item_in;
          rem_rows_next = item_in.row_count;
          rem_cols_next = cfg.total_cols;
          row_idx_next = '0;
          col_idx_next = '0;
          tile_cnt_next = '0;
          state_next = ST_START;
        end
      end
      ST_START: begin
        if (can_load) begin
          load = 1'b1;
          rec.record_kind = KIND_START;
          rec.group_index = group_counter;
          rec.start_row = running_start_row;
          rec.group_rows = item.row_count;
          rec.last_result = !tiles_go && !item.last;
          if (tiles_go) begin
            state_next = ST_TILE;
          end else if (item.last) begin
            state_next = ST_TOTAL;
          end else begin
            finish_group = 1'b1;
            state_next = ST_IDLE;
          end
        end
      end
      ST_TILE: begin
        if (can_load) begin
          load = 1'b1;
          rec.record_kind = KIND_TILE;
          rec.group_index = group_counter;
          rec.start_row = running_start_row;
          rec.tile_row_index = row_idx;
          rec.tile_col_index = col_idx;
          rec.tile_rows = tile_rows_c;
          rec.tile_cols = tile_cols_c;
          rec.group_rows = item.row_count;
          tiles_issued_next = issued_inc;
          tile_cnt_next = cnt_inc;
          if (rem_cols > bc) begin
            rem_cols_next = rem_cols - bc;
            col_idx_next = col_idx + 16'd1;
          end else begin
            rem_cols_next = cfg.total_cols;
            col_idx_next = '0;
            if (rem_rows > {16'd0, br}) begin
              rem_rows_next = rem_rows - {16'd0, br};
              row_idx_next = row_idx + 16'd1;
            end else begin
              rows_done = 1'b1;
            end
          end
          more = !rows_done && (cnt_inc < CW'(MAX_TILES_PER_GROUP)) &&
                 (issued_inc < cfg.max_blocks);
          rec.last_result = !more && !item.last;
          if (more) begin
            state_next = ST_TILE;
          end else if (item.last) begin
            state_next = ST_TOTAL;
          end else begin
            finish_group = 1'b1;
            state_next = ST_IDLE;
          end
        end
      end
      ST_TOTAL: begin
        if (can_load) begin
          load = 1'b1;
          rec.record_kind = KIND_TOTAL;
          rec.group_index = group_counter;
          rec.block_total = tiles_issued;
          rec.last_result = 1'b1;
          running_start_row_next = '0;
          group_counter_next = '0;
          tiles_issued_next = '0;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase

    if (finish_group) begin
      if (item.positive) begin
        running_start_row_next = running_start_row + item.row_count;
      end
      group_counter_next = group_counter + 16'd1;
    end

    if (load) begin
      out_valid_next = 1'b1;
      out_rec_next = rec;
    end else begin
      out_valid_next = out_valid && !out_ready;
      out_rec_next = out_rec;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      running_start_row <= '0;
      group_counter <= '0;
      tiles_issued <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      running_start_row <= running_start_row_next;
      group_counter <= group_counter_next;
      tiles_issued <= tiles_issued_next;
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    item <= item_next;
    rem_rows <= rem_rows_next;
    rem_cols <= rem_cols_next;
    row_idx <= row_idx_next;
    col_idx <= col_idx_next;
    tile_cnt <= tile_cnt_next;
    out_rec <= out_rec_next;
  end

endmodule

FILE: design/gtsg_checker.sv
// Port-level checks on the result stream of the grouped tile schedule generator.
// Depends on gtsg_pkg and the assertion macro header; bound to the top level.
`include "grouped_tile_schedule_generator_top_assert.svh"

module gtsg_checker import gtsg_pkg::*; (
  input logic               clk,
  input logic               rst,
  input logic               m_axis_tvalid,
  input logic               m_axis_tready,
  input logic [TDATA_W-1:0] m_axis_tdata,
  input logic [1:0]         m_axis_tuser,
  input logic               m_axis_tlast
);

  `GTSG_ASSERT_NXT_ALWAYS(a_reset_clears, clk, rst, !m_axis_tvalid, "result valid after reset")
  `GTSG_ASSERT_NXT(a_stall_holds, clk, rst, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "stalled result changed")
  `GTSG_ASSERT_IMP(a_total_last, clk, rst, m_axis_tvalid && (m_axis_tuser == KIND_TOTAL), m_axis_tlast, "total record not last")
  `GTSG_ASSERT_IMP(a_tile_nonempty, clk, rst, m_axis_tvalid && (m_axis_tuser == KIND_TILE), (m_axis_tdata[95:80] != 16'd0) && (m_axis_tdata[111:96] != 16'd0), "empty tile entry")

endmodule

bind grouped_tile_schedule_generator_top gtsg_checker u_gtsg_checker (.*);

FILE: tb/grouped_tile_schedule_generator_top_test.sv
// Self-checking testbench for grouped_tile_schedule_generator_top: stream groups in,
// predict every start, tile and total record, and compare each output transfer.
// Depends on gtsg_pkg and the top module of the block only.
module grouped_tile_schedule_generator_top_test;
  import gtsg_pkg::*;

  localparam int GROUP_TILE_CAP = 62;
  localparam int STALL_LIMIT = 4000;

  logic               clk;
  logic               rst;
  logic               s_axis_tvalid;
  logic               s_axis_tready;
  logic [31:0]        s_axis_tdata;  // row_count [31:0]
  logic               s_axis_tlast;  // last_group
  logic               m_axis_tvalid;
  logic               m_axis_tready;
  // group_index, start_row, tile_row_index, tile_col_index, tile_rows, tile_cols,
  // group_rows, block_total, then zero fill
  logic [TDATA_W-1:0] m_axis_tdata;
  logic [1:0]         m_axis_tuser;  // record_kind
  logic               m_axis_tlast;  // last_result
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [3:0]         paddr;
  logic [31:0]        pwdata;
  logic [31:0]        prdata;
  logic               pready;

  grouped_tile_schedule_generator_top #(
    .MAX_TILES_PER_GROUP(GROUP_TILE_CAP)
  ) dut (
    .clk(clk),
    .rst(rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .s_axis_tlast(s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .m_axis_tuser(m_axis_tuser),
    .m_axis_tlast(m_axis_tlast),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  logic [15:0] cfg_base_rows = RST_BASE_ROWS;
  logic [15:0] cfg_base_cols = RST_BASE_COLS;
  logic [15:0] cfg_total_cols = RST_TOTAL_COLS;
  logic [20:0] cfg_max_blocks = RST_MAX_BLOCKS;

  logic [31:0] row_base = '0;
  logic [15:0] next_group = '0;
  logic [20:0] batch_tiles = '0;

  gtsg_result_t schedule_q[$];
  gtsg_result_t held_record;
  bit           record_held = 1'b0;
  gtsg_result_t want;

  int src_idle_pct = 0;
  int rx_stall_pct = 0;
  int fail_count = 0;
  int groups_sent = 0;
  int starts_seen = 0;
  int tiles_seen = 0;
  int totals_seen = 0;
  int quiet_cycles = 0;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic void stage_record(gtsg_result_t rec);
    if (record_held) schedule_q.push_back(held_record);
    held_record = rec;
    record_held = 1'b1;
  endfunction

  // Expands one accepted group into the records the block must emit.
  function automatic void plan_group(logic [31:0] raw, logic last);
    gtsg_result_t rec;
    longint unsigned rows, br, bc, col_tiles, row_tiles, i, j, rr, cc;
    int produced;
    rows = raw;
    br = (cfg_base_rows == 0) ? 1 : cfg_base_rows;
    bc = (cfg_base_cols == 0) ? 1 : cfg_base_cols;
    col_tiles = (cfg_total_cols + bc - 1) / bc;
    rec = '0;
    rec.record_kind = KIND_START;
    rec.group_index = next_group;
    rec.start_row = row_base;
    rec.group_rows = raw;
    stage_record(rec);
    if (raw != 0 && !raw[31]) begin
      row_tiles = (rows + br - 1) / br;
      i = 0;
      j = 0;
      produced = 0;
      if (col_tiles != 0) begin
        while (i < row_tiles && produced < GROUP_TILE_CAP && batch_tiles < cfg_max_blocks) begin
          rr = rows - i * br;
          cc = cfg_total_cols - j * bc;
          if (rr > br) rr = br;
          if (cc > bc) cc = bc;
          rec = '0;
          rec.record_kind = KIND_TILE;
          rec.group_index = next_group;
          rec.start_row = row_base;
          rec.tile_row_index = i[15:0];
          rec.tile_col_index = j[15:0];
          rec.tile_rows = rr[15:0];
          rec.tile_cols = cc[15:0];
          rec.group_rows = raw;
          stage_record(rec);
          batch_tiles = batch_tiles + 21'd1;
          produced++;
          j++;
          if (j >= col_tiles) begin
            j = 0;
            i++;
          end
        end
      end
      row_base = row_base + raw;
    end
    if (last) begin
      rec = '0;
      rec.record_kind = KIND_TOTAL;
      rec.group_index = next_group;
      rec.block_total = batch_tiles;
      stage_record(rec);
      row_base = '0;
      next_group = '0;
      batch_tiles = '0;
    end else begin
      next_group = next_group + 16'd1;
    end
    held_record.last_result = 1'b1;
    schedule_q.push_back(held_record);
    record_held = 1'b0;
  endfunction

  function automatic void check_field(string name, longint unsigned exp_val,
                                      longint unsigned act_val);
    if (exp_val != act_val) begin
      $error("%s mismatch: expected 0x%0h, got 0x%0h", name, exp_val, act_val);
      fail_count++;
    end
  endfunction

  always @(negedge clk) begin
    m_axis_tready <= ($urandom_range(99) >= rx_stall_pct);
  end

  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      case (m_axis_tuser)
        KIND_START: starts_seen++;
        KIND_TILE:  tiles_seen++;
        default:    totals_seen++;
      endcase
      if (schedule_q.size() == 0) begin
        $error("unexpected record transfer: kind %0d, tdata 0x%0h", m_axis_tuser, m_axis_tdata);
        fail_count++;
      end else begin
        want = schedule_q.pop_front();
        check_field("record_kind", want.record_kind, m_axis_tuser);
        check_field("group_index", want.group_index, m_axis_tdata[15:0]);
        check_field("start_row", $unsigned(want.start_row), m_axis_tdata[47:16]);
        check_field("tile_row_index", want.tile_row_index, m_axis_tdata[63:48]);
        check_field("tile_col_index", want.tile_col_index, m_axis_tdata[79:64]);
        check_field("tile_rows", want.tile_rows, m_axis_tdata[95:80]);
        check_field("tile_cols", want.tile_cols, m_axis_tdata[111:96]);
        check_field("group_rows", $unsigned(want.group_rows), m_axis_tdata[143:112]);
        check_field("block_total", want.block_total, m_axis_tdata[164:144]);
        check_field("tdata fill", 0, m_axis_tdata[TDATA_W-1:165]);
        check_field("last_result", want.last_result, m_axis_tlast);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (psel && penable && pready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $error("no transfer for %0d cycles, %0d records outstanding", quiet_cycles,
               schedule_q.size());
        $display("Some tests failed");
        $finish;
      end
    end
  end

  task automatic idle_input();
    s_axis_tvalid <= 1'b0;
    @(negedge clk);
  endtask

  task automatic send_group(input logic [31:0] rows, input logic last);
    if (src_idle_pct != 0 && $urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      do @(negedge clk); while ($urandom_range(99) < src_idle_pct);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= rows;
    s_axis_tlast <= last;
    do @(posedge clk); while (!s_axis_tready);
    plan_group(rows, last);
    groups_sent++;
    @(negedge clk);
  endtask

  task automatic wait_drained();
    idle_input();
    while (schedule_q.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(input logic [1:0] which, input logic [31:0] value);
    idle_input();
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= {which, 2'b00};
    pwdata <= value;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    case (which)
      REG_BASE_ROWS:  cfg_base_rows = value[15:0];
      REG_BASE_COLS:  cfg_base_cols = value[15:0];
      REG_TOTAL_COLS: cfg_total_cols = value[15:0];
      default:        cfg_max_blocks = value[20:0];
    endcase
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic restore_registers();
    wait_drained();
    write_reg(REG_BASE_ROWS, RST_BASE_ROWS);
    write_reg(REG_BASE_COLS, RST_BASE_COLS);
    write_reg(REG_TOTAL_COLS, RST_TOTAL_COLS);
    write_reg(REG_MAX_BLOCKS, RST_MAX_BLOCKS);
  endtask

  task automatic shuffle_registers();
    wait_drained();
    case ($urandom_range(3))
      0: write_reg(REG_BASE_ROWS, $urandom_range(1, 16));
      1: write_reg(REG_BASE_ROWS, $urandom_range(1, 1024));
      2: write_reg(REG_BASE_ROWS, 32'hFFFF);
      default: write_reg(REG_BASE_ROWS, $urandom());
    endcase
    case ($urandom_range(3))
      0: write_reg(REG_BASE_COLS, $urandom_range(1, 64));
      1: write_reg(REG_BASE_COLS, $urandom_range(1, 4096));
      2: write_reg(REG_BASE_COLS, 32'hFFFF);
      default: write_reg(REG_BASE_COLS, $urandom());
    endcase
    write_reg(REG_TOTAL_COLS, ($urandom_range(3) == 0) ? 32'hFFFF : $urandom_range(1, 8192));
    write_reg(REG_MAX_BLOCKS, ($urandom_range(2) == 0) ? $urandom_range(0, 40) : $urandom());
  endtask

  function automatic logic [31:0] pick_rows();
    int br;
    br = (cfg_base_rows == 0) ? 1 : cfg_base_rows;
    case ($urandom_range(9))
      0: return $urandom() | 32'h8000_0000;
      1: return $urandom();
      2: return 32'd0;
      default: return $urandom_range(1, 3 * br);
    endcase
  endfunction

  task automatic test_default_tiling();
    send_group(32'd300, 1'b0);
    send_group(32'd1, 1'b0);
    send_group(32'd129, 1'b1);
  endtask

  // Empty and negative groups, the largest count against the per-group tile cap,
  // and a running start row that wraps past 32 bits.
  task automatic test_row_count_extremes();
    send_group(32'd0, 1'b0);
    send_group(32'hFFFF_FFFF, 1'b0);
    send_group(32'h8000_0000, 1'b0);
    send_group(32'h7FFF_FFFF, 1'b0);
    send_group(32'h7FFF_FFFF, 1'b0);
    send_group(32'd3, 1'b0);
    send_group(32'd1, 1'b1);
    send_group(32'd0, 1'b1);
  endtask

  task automatic test_register_corners();
    wait_drained();
    write_reg(REG_BASE_ROWS, 32'hABCD_0000);
    write_reg(REG_BASE_COLS, 32'd0);
    write_reg(REG_TOTAL_COLS, 32'd3);
    send_group(32'd2, 1'b1);
    wait_drained();
    write_reg(REG_BASE_ROWS, 32'hFFFF);
    write_reg(REG_BASE_COLS, 32'hFFFF);
    write_reg(REG_TOTAL_COLS, 32'hFFFF);
    send_group(32'h7FFF_FFFF, 1'b0);
    send_group(32'd70000, 1'b1);
    wait_drained();
    write_reg(REG_TOTAL_COLS, 32'd0);
    send_group(32'd100, 1'b1);
    wait_drained();
    write_reg(REG_TOTAL_COLS, 32'd4096);
    write_reg(REG_MAX_BLOCKS, 32'd0);
    send_group(32'd100, 1'b1);
    wait_drained();
    write_reg(REG_MAX_BLOCKS, 32'hFFFF_FFFF);
    write_reg(REG_BASE_ROWS, 32'd4);
    send_group(32'd10, 1'b1);
    wait_drained();
    write_reg(REG_MAX_BLOCKS, 32'd5);
    write_reg(REG_BASE_COLS, 32'd1024);
    send_group(32'd3, 1'b0);
    send_group(32'd200, 1'b0);
    send_group(32'd50, 1'b1);
    restore_registers();
  endtask

  task automatic test_random_batches();
    for (int phase = 0; phase < 4; phase++) begin
      wait_drained();
      case (phase)
        0: begin
          src_idle_pct = 0;
          rx_stall_pct = 0;
        end
        1: begin
          src_idle_pct = 87;
          rx_stall_pct = 0;
        end
        2: begin
          src_idle_pct = 0;
          rx_stall_pct = 87;
        end
        default: begin
          src_idle_pct = 30;
          rx_stall_pct = 30;
        end
      endcase
      shuffle_registers();
      for (int k = 0; k < 38; k++) begin
        if (k == 19) wait_drained();
        send_group(pick_rows(), (k == 37) || ($urandom_range(5) == 0));
      end
    end
    src_idle_pct = 0;
    rx_stall_pct = 0;
  endtask

  initial begin
    rst = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tlast = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    test_default_tiling();
    test_row_count_extremes();
    test_register_corners();
    test_random_batches();

    idle_input();
    while (schedule_q.size() != 0) @(negedge clk);
    repeat (40) @(negedge clk);
    if (schedule_q.size() != 0) begin
      $error("%0d expected records never arrived", schedule_q.size());
      fail_count++;
    end

    $display("Covered %0d groups: %0d start records, %0d tile entries, %0d batch totals,",
             groups_sent, starts_seen, tiles_seen, totals_seen);
    $display("with zero and full-width tile sizes, batch and group limits, and four idle patterns.");
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

FILE: filelist.f
+incdir+design
design/gtsg_pkg.sv
design/gtsg_front.sv
design/gtsg_back.sv
design/grouped_tile_schedule_generator_top.sv
design/gtsg_checker.sv
tb/grouped_tile_schedule_generator_top_test.sv
